FILE: rtl/sthac_pkg.sv
package sthac_pkg;

    // table geometry
    localparam int MAX_BINS   = 1024;
    localparam int GROUP_SIZE = 32;
    localparam int NUM_GROUPS = MAX_BINS / GROUP_SIZE;

    // field widths
    localparam int SLOT_W    = 10;
    localparam int USED_W    = 11;
    localparam int TIME_W    = 40;
    localparam int COUNT_W   = 32;
    localparam int TRIG_W    = 32;
    localparam int OFFSET_W  = 32;
    localparam int HIT_IDX_W = 20;
    localparam int FRAC_W    = 16;
    localparam int BIN_W     = TIME_W + 1 - FRAC_W;

    // stream payload widths
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 120;

    // request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_TRIGGER = 2'd0,
        REQ_HIT     = 2'd1,
        REQ_READ    = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    // result status carried in m_tuser
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // operation broadcast to every cell
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_HIT_CMP,
        CMD_READ_CMP,
        CMD_INC,
        CMD_INSERT
    } cell_op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIN,
        ST_CMP,
        ST_GATHER_A,
        ST_GATHER_B,
        ST_APPLY
    } state_t;

    // broadcast bus from the sequencer to the cells
    typedef struct packed {
        cell_op_t                   op;
        logic signed [BIN_W-1:0]    bin;
        logic signed [TIME_W-1:0]   tval;
        logic [SLOT_W-1:0]          slot;
        logic [USED_W-1:0]          used;
    } cell_cmd_t;

    // contents handed from one cell to the next
    typedef struct packed {
        logic                       lt;
        logic signed [BIN_W-1:0]    bin;
        logic signed [TIME_W-1:0]   tval;
        logic [COUNT_W-1:0]         count;
    } cell_link_t;

    // selected entry travelling up the gather tree
    typedef struct packed {
        logic                       found;
        logic signed [TIME_W-1:0]   tval;
        logic [COUNT_W-1:0]         count;
    } gather_t;

endpackage

FILE: rtl/sthac_cell.sv
module sthac_cell
    import sthac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SLOT_W-1:0] cell_idx,
    input  cell_cmd_t        cmd,
    input  cell_link_t       prev,
    output cell_link_t       link,
    output gather_t          tap
);

    logic signed [BIN_W-1:0]  bin_reg,   bin_next;
    logic signed [TIME_W-1:0] tval_reg,  tval_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     lt_reg,    lt_next;
    logic                     sel_reg,   sel_next;
    logic                     occupied;

    // slot holds a live entry when it lies below the fill level
    assign occupied = ({1'b0, cell_idx} < cmd.used);

    // compare, increment and shift-insert
    always_comb
    begin
        bin_next   = bin_reg;
        tval_next  = tval_reg;
        count_next = count_reg;
        lt_next    = lt_reg;
        sel_next   = sel_reg;
        unique case (cmd.op)
            CMD_HIT_CMP:
            begin
                lt_next  = occupied && (bin_reg < cmd.bin);
                sel_next = occupied && (bin_reg == cmd.bin);
            end
            CMD_READ_CMP:
            begin
                lt_next  = 1'b0;
                sel_next = occupied && (cell_idx == cmd.slot);
            end
            CMD_INC:
            begin
                if (sel_reg && (count_reg != {COUNT_W{1'b1}}))
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (!lt_reg)
                begin
                    if (prev.lt)
                    begin
                        // first slot with a larger bin, or the first free slot, takes the new entry
                        bin_next   = cmd.bin;
                        tval_next  = cmd.tval;
                        count_next = COUNT_W'(1);
                    end
                    else
                    begin
                        // slots above the insertion point move up by one
                        bin_next   = prev.bin;
                        tval_next  = prev.tval;
                        count_next = prev.count;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        tval_reg  <= tval_next;
        count_reg <= count_next;
    end

    // compare flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg  <= 1'b0;
            sel_reg <= 1'b0;
        end
        else
        begin
            lt_reg  <= lt_next;
            sel_reg <= sel_next;
        end
    end

    // neighbour link and gather tap
    assign link.lt    = lt_reg;
    assign link.bin   = bin_reg;
    assign link.tval  = tval_reg;
    assign link.count = count_reg;

    assign tap.found = sel_reg;
    assign tap.tval  = sel_reg ? tval_reg : '0;
    assign tap.count = sel_reg ? count_reg : '0;

endmodule

FILE: rtl/sthac_gather.sv
module sthac_gather
    import sthac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  gather_t taps [GROUP_SIZE],
    output gather_t result
);

    gather_t merged;
    logic    found_reg;
    logic signed [TIME_W-1:0] tval_reg;
    logic [COUNT_W-1:0]       count_reg;

    // at most one tap is selected, so an or merge picks it
    always_comb
    begin
        merged = '0;
        for (int k = 0; k < GROUP_SIZE; k++)
        begin
            merged.found = merged.found | taps[k].found;
            merged.tval  = merged.tval  | taps[k].tval;
            merged.count = merged.count | taps[k].count;
        end
    end

    // registered tree level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= merged.found;
        end
    end

    always_ff @(posedge clk)
    begin
        tval_reg  <= merged.tval;
        count_reg <= merged.count;
    end

    assign result.found = found_reg;
    assign result.tval  = tval_reg;
    assign result.count = count_reg;

endmodule

FILE: rtl/sorted_time_histogram_accumulator_core.sv
// Sorted time histogram accumulator.
// Requests enter on the s_ stream: s_tuser selects trigger start, hit, read
// slot or clear, and s_tdata carries offset, hit index and read slot. Every
// request yields exactly one result transaction on the m_ stream, with the
// status in m_tuser and entry time, count, entries used and triggers seen in
// m_tdata. The table is a chain of 1024 cells kept in ascending bin order; a
// hit is broadcast to all cells, each compares its own bin, and the matching
// cell counts up or all cells past the insertion point shift up by one.
// Path from the accepting edge to m_tvalid: trigger start and clear go straight
// to the update step; a read passes broadcast compare, two registered gather
// levels of 32 and the update, and a hit adds rounding before them. One request
// is in flight at a time, so no new request is taken before the last is done.
// A new request is taken as soon as the previous one has reached the output
// register; if the receiver stalls, the following request waits in its
// final step until the output register is free, and s_tready stays low.
// Reset empties the table at once (no clearing pass), zeroes the trigger
// count and the latched offset, and drops any pending result.
module sorted_time_histogram_accumulator_core
    import sthac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // trigger_offset[31:0], hit_index[51:32], read_slot[61:52], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // entry_time[39:0], entry_count[71:40], entries_used[82:72],
    // triggers_seen[114:83], zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]          m_tuser
);

    state_t state_reg, state_next;
    req_t   req_reg,   req_next;

    logic signed [OFFSET_W-1:0] offset_in_reg, offset_in_next;
    logic signed [OFFSET_W-1:0] offset_reg,    offset_next;
    logic [SLOT_W-1:0]          slot_reg,      slot_next;
    logic signed [TIME_W-1:0]   t_reg,         t_next;
    logic signed [BIN_W-1:0]    bin_reg,       bin_next;
    logic [USED_W-1:0]          used_reg,      used_next;
    logic [TRIG_W-1:0]          trig_reg,      trig_next;

    logic                       out_valid_reg, out_valid_next;
    status_t                    out_status_reg, out_status_next;
    logic signed [TIME_W-1:0]   out_time_reg,  out_time_next;
    logic [COUNT_W-1:0]         out_count_reg, out_count_next;
    logic [USED_W-1:0]          out_used_reg,  out_used_next;
    logic [TRIG_W-1:0]          out_trig_reg,  out_trig_next;

    logic                       in_accept;
    logic signed [OFFSET_W-1:0] in_offset;
    logic [HIT_IDX_W-1:0]       in_index;
    logic [SLOT_W-1:0]          in_slot;
    logic signed [TIME_W:0]     time_sum;
    logic signed [TIME_W-1:0]   hit_time;
    logic                       t_neg;
    logic [TIME_W:0]            t_mag;
    logic [TIME_W:0]            t_round;
    logic [BIN_W-1:0]           bin_mag;
    logic                       out_free;

    cell_cmd_t  cmd;
    cell_link_t head_link;
    cell_link_t links     [MAX_BINS];
    gather_t    cell_taps [NUM_GROUPS][GROUP_SIZE];
    gather_t    group_res [NUM_GROUPS];
    gather_t    final_res;

    // input unpacking
    assign in_offset = s_tdata[OFFSET_W-1:0];
    assign in_index  = s_tdata[OFFSET_W +: HIT_IDX_W];
    assign in_slot   = s_tdata[OFFSET_W+HIT_IDX_W +: SLOT_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // hit time: offset plus index in Q.16, saturated to the time range
    always_comb
    begin
        time_sum = {{(TIME_W+1-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg}
                 + {{(TIME_W+1-HIT_IDX_W-FRAC_W){1'b0}}, in_index, {FRAC_W{1'b0}}};
        if (time_sum[TIME_W] != time_sum[TIME_W-1])
        begin
            hit_time = time_sum[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}}
                                        : {1'b0, {(TIME_W-1){1'b1}}};
        end
        else
        begin
            hit_time = time_sum[TIME_W-1:0];
        end
    end

    // bin: round half away from zero on the magnitude
    always_comb
    begin
        t_neg   = t_reg[TIME_W-1];
        t_mag   = t_neg ? ((TIME_W+1)'(0) - {t_reg[TIME_W-1], t_reg})
                        : {t_reg[TIME_W-1], t_reg};
        t_round = t_mag + ((TIME_W+1)'(1) << (FRAC_W-1));
        bin_mag = t_round[TIME_W:FRAC_W];
        bin_next = t_neg ? ((BIN_W)'(0) - bin_mag) : bin_mag;
    end

    // sequencer: next state, cell command and result
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        offset_in_next  = offset_in_reg;
        offset_next     = offset_reg;
        slot_next       = slot_reg;
        t_next          = t_reg;
        used_next       = used_reg;
        trig_next       = trig_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_time_next   = out_time_reg;
        out_count_next  = out_count_reg;
        out_used_next   = out_used_reg;
        out_trig_next   = out_trig_reg;

        cmd.op   = CMD_NONE;
        cmd.bin  = bin_reg;
        cmd.tval = t_reg;
        cmd.slot = slot_reg;
        cmd.used = used_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_next       = req_t'(s_tuser);
                    offset_in_next = in_offset;
                    slot_next      = in_slot;
                    t_next         = hit_time;
                    unique case (req_t'(s_tuser))
                        REQ_HIT:  state_next = ST_BIN;
                        REQ_READ: state_next = ST_CMP;
                        default:  state_next = ST_APPLY;
                    endcase
                end
            end
            ST_BIN:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.op     = (req_reg == REQ_HIT) ? CMD_HIT_CMP : CMD_READ_CMP;
                state_next = ST_GATHER_A;
            end
            ST_GATHER_A:
            begin
                state_next = ST_GATHER_B;
            end
            ST_GATHER_B:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_time_next   = '0;
                    out_count_next  = '0;
                    unique case (req_reg)
                        REQ_TRIGGER:
                        begin
                            offset_next = offset_in_reg;
                            if (trig_reg != {TRIG_W{1'b1}})
                            begin
                                trig_next = trig_reg + TRIG_W'(1);
                            end
                        end
                        REQ_HIT:
                        begin
                            if (final_res.found)
                            begin
                                cmd.op        = CMD_INC;
                                out_time_next = final_res.tval;
                                out_count_next = (final_res.count != {COUNT_W{1'b1}})
                                               ? final_res.count + COUNT_W'(1)
                                               : final_res.count;
                            end
                            else if (used_reg == USED_W'(MAX_BINS))
                            begin
                                out_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                cmd.op         = CMD_INSERT;
                                used_next      = used_reg + USED_W'(1);
                                out_time_next  = t_reg;
                                out_count_next = COUNT_W'(1);
                            end
                        end
                        REQ_READ:
                        begin
                            if (final_res.found)
                            begin
                                out_time_next  = final_res.tval;
                                out_count_next = final_res.count;
                            end
                            else
                            begin
                                out_status_next = STATUS_EMPTY;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            used_next = '0;
                            trig_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_used_next = used_next;
                    out_trig_next = trig_next;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            trig_reg      <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            trig_reg      <= trig_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        offset_in_reg  <= offset_in_next;
        slot_reg       <= slot_next;
        t_reg          <= t_next;
        bin_reg        <= bin_next;
        out_status_reg <= out_status_next;
        out_time_reg   <= out_time_next;
        out_count_reg  <= out_count_next;
        out_used_reg   <= out_used_next;
        out_trig_reg   <= out_trig_next;
    end

    // first cell always sees an insertion point just below it
    assign head_link.lt    = 1'b1;
    assign head_link.bin   = '0;
    assign head_link.tval  = '0;
    assign head_link.count = '0;

    // cell chain
    for (genvar i = 0; i < MAX_BINS; i++)
    begin : g_cell
        cell_link_t prev_link;
        if (i == 0)
        begin : g_head
            assign prev_link = head_link;
        end
        else
        begin : g_body
            assign prev_link = links[i-1];
        end
        sthac_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (SLOT_W'(i)),
            .cmd      (cmd),
            .prev     (prev_link),
            .link     (links[i]),
            .tap      (cell_taps[i / GROUP_SIZE][i % GROUP_SIZE])
        );
    end

    // first gather level, one per group of cells
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        sthac_gather u_gather (
            .clk    (clk),
            .rst_n  (rst_n),
            .taps   (cell_taps[g]),
            .result (group_res[g])
        );
    end

    // second gather level over the groups
    sthac_gather u_gather_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .taps   (group_res),
        .result (final_res)
    );

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_DATA_W-TIME_W-COUNT_W-USED_W-TRIG_W){1'b0}},
                       out_trig_reg, out_used_reg, out_count_reg, out_time_reg};

endmodule
